FILE: hw/rtl/eci_pkg.sv
// ----------------------------------------------------------------------------
// eci_pkg: shared types and constants of the easing curve interpolator
// Curve codes, sideband word carried along the pipeline, quarter-sine ROM math.
// ----------------------------------------------------------------------------
package eci_pkg;

  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_SINE   = 3'd1;
  localparam logic [2:0] MODE_COSINE = 3'd2;
  localparam logic [2:0] MODE_POLY5  = 3'd3;
  localparam logic [2:0] MODE_MPOLY5 = 3'd4;
  localparam logic [2:0] MODE_MIXED  = 3'd5;

  // how the fraction t is resolved
  typedef enum logic [1:0] {
    CLS_DIV,
    CLS_ZERO,
    CLS_ONE
  } cls_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [16:0] rng;       // end - start, two's complement
    logic        done;
    logic        inval;
    logic        mix_full;  // mixed curve with zero duration
    logic        mix_hi;    // mixed curve, second half
    cls_e        cls;
  } side_t;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  // sin(x), x in Q30, Taylor series, rounded to Q0.frac and capped at 1.0
  function automatic logic [63:0] rom_entry(input logic [63:0] x, input int frac);
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] v;
    term = x;
    sum  = $signed(x);
    for (int k = 0; k < 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / SIN_DIV[k];
      if ((k % 2) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) << frac) + (64'd1 << 29)) >> 30;
    if (v > (64'd1 << frac)) begin
      v = 64'd1 << frac;
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/eci_div.sv
// ----------------------------------------------------------------------------
// eci_div: pipelined restoring divider
// One quotient bit per stage; numerator must be below the denominator.
// ----------------------------------------------------------------------------
module eci_div #(
  parameter int QW = 16,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p, den_p, rem_d;
    logic [QW-1:0] quo_p, quo_d;
    logic [DW:0]   sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign sh    = {rem_p, 1'b0};
    assign ge    = sh >= {1'b0, den_p};
    assign rem_d = ge ? DW'(sh - {1'b0, den_p}) : sh[DW-1:0];
    assign quo_d = {quo_p[QW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_p;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

FILE: hw/rtl/easing_curve_interpolator.sv
// ----------------------------------------------------------------------------
// easing_curve_interpolator: eased offset between two coordinates
// Forms t = clamp(elapsed / duration) in Q0.FRAC_BITS, applies one of six
// curves (linear, sine, one-minus-cosine, t^5, inverted t^5, mixed) and scales
// the range end - start by it, truncated toward zero.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | word fields
//  --------+--------------------------+----------------------------------------
//  in      | in_valid_i, in_stall_o   | curve mode, two times, duration, values
//  out     | out_valid_o, out_stall_i | offset_o, done_res_o, invalid_o
//
// One word enters per cycle unless a valid output word is stalled. Stages 1 to 3,
// the divider (one quotient bit per stage) and stages 4 to 10 follow in order.
// The whole pipeline, bubbles included, holds while a valid output word is
// stalled; otherwise every stage moves on each cycle.
// Reset clears the valid bits only. The sine table is a constant ROM.
// ----------------------------------------------------------------------------
module easing_curve_interpolator #(
  parameter int FRAC_BITS   = 16,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  curve_mode_i,
  input  logic [31:0] start_time_i,
  input  logic [31:0] now_time_i,
  input  logic [23:0] duration_i,
  input  logic signed [15:0] start_value_i,
  input  logic signed [15:0] end_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [16:0] offset_o,
  output logic        done_res_o,
  output logic        invalid_o
);

  import eci_pkg::*;

  localparam int TW = FRAC_BITS + 1;               // t, 0..1.0
  localparam int NW = FRAC_BITS + 2;               // eased value, 0..1.0
  localparam int IW = $clog2(TABLE_DEPTH + 1);     // ROM index
  localparam int PW = TW + IW;                     // t * depth
  localparam logic [TW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH);

  // -------- quarter-wave sine ROM, built at elaboration
  logic [TW-1:0] rom_c [TABLE_DEPTH+1];
  for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_rom
    localparam longint unsigned X = HALF_PI_Q30 * i / TABLE_DEPTH;
    localparam logic [63:0] V = rom_entry(X, FRAC_BITS);
    if (i == 0) begin : g_zero
      assign rom_c[i] = '0;
    end else if (i == TABLE_DEPTH) begin : g_top
      assign rom_c[i] = ONE_Q;
    end else begin : g_mid
      assign rom_c[i] = V[TW-1:0];
    end
  end

  // -------- pipeline advance: everything holds while the output word waits
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic vd_q [FRAC_BITS];

  assign adv        = !(v10_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      for (int k = 0; k < FRAC_BITS; k++) vd_q[k] <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vd_q[0] <= v3_q;
      for (int k = 1; k < FRAC_BITS; k++) vd_q[k] <= vd_q[k-1];
      v4_q  <= vd_q[FRAC_BITS-1];
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  // -------- stage 1: elapsed time and range
  logic [31:0] el1_q;
  logic [23:0] dur1_q;
  logic [2:0]  mode1_q;
  logic [16:0] rng1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      el1_q   <= now_time_i - start_time_i;
      dur1_q  <= duration_i;
      mode1_q <= curve_mode_i;
      rng1_q  <= 17'({end_value_i[15], end_value_i} - {start_value_i[15], start_value_i});
    end
  end

  // -------- stage 2: done flag, mixed-curve half select, divider operands
  logic [32:0] el1_x;
  logic [22:0] h1;
  logic        mix1, mixdiv1, hi1;
  side_t       side2_q;
  logic [32:0] n2_q;
  logic [23:0] den2_q;

  assign el1_x   = {el1_q[31], el1_q};
  assign h1      = dur1_q[23:1];
  assign mix1    = (mode1_q == MODE_MIXED);
  assign mixdiv1 = mix1 && (dur1_q != '0);
  assign hi1     = mixdiv1 && ($signed(el1_x) > $signed({10'b0, h1}));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q.mode     <= mode1_q;
      side2_q.rng      <= rng1_q;
      side2_q.done     <= $signed(el1_x) >= $signed({9'b0, dur1_q});
      side2_q.inval    <= (mode1_q > MODE_MIXED);
      side2_q.mix_full <= mix1 && (dur1_q == '0);
      side2_q.mix_hi   <= hi1;
      side2_q.cls      <= CLS_DIV;
      n2_q             <= hi1 ? 33'(el1_x - {10'b0, h1}) : el1_x;
      den2_q           <= mixdiv1 ? {1'b0, h1} : dur1_q;
    end
  end

  // -------- stage 3: clamp class
  side_t       side3_c, side3_q;
  logic [23:0] dnum3_q, dden3_q;

  always_comb begin
    side3_c = side2_q;
    if (den2_q == '0) begin
      side3_c.cls = CLS_ONE;
    end else if (n2_q[32] || (n2_q == '0)) begin
      side3_c.cls = CLS_ZERO;
    end else if (n2_q[31:0] >= {8'b0, den2_q}) begin
      side3_c.cls = CLS_ONE;
    end else begin
      side3_c.cls = CLS_DIV;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side3_c;
      dnum3_q <= n2_q[23:0];
      dden3_q <= den2_q;
    end
  end

  // -------- divider, sideband delayed alongside
  logic [FRAC_BITS-1:0] quo;
  side_t sd_q [FRAC_BITS];

  eci_div #(
    .QW(FRAC_BITS),
    .DW(24)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (dnum3_q),
    .den_i (dden3_q),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side3_q;
      for (int k = 1; k < FRAC_BITS; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // -------- stage 4: t, curve argument, ROM address
  side_t         sdo;
  logic [TW-1:0] t_c, a_c;
  logic          inv_c;
  logic [PW-1:0] p_c;

  assign sdo = sd_q[FRAC_BITS-1];

  always_comb begin
    case (sdo.cls)
      CLS_ONE:  t_c = ONE_Q;
      CLS_ZERO: t_c = '0;
      default:  t_c = {1'b0, quo};
    endcase
  end

  assign inv_c = (sdo.mode == MODE_COSINE) || (sdo.mode == MODE_MPOLY5) ||
                 ((sdo.mode == MODE_MIXED) && sdo.mix_hi);
  assign a_c   = inv_c ? TW'(ONE_Q - t_c) : t_c;
  assign p_c   = PW'(a_c) * PW'(TABLE_DEPTH);

  side_t                side4_q;
  logic [TW-1:0]        t4_q, a4_q;
  logic [IW-1:0]        idx4_q, idx14_q;
  logic [FRAC_BITS-1:0] frac4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= sdo;
      t4_q    <= t_c;
      a4_q    <= a_c;
      idx4_q  <= p_c[FRAC_BITS +: IW];
      idx14_q <= (p_c[FRAC_BITS +: IW] == LAST_IDX) ? LAST_IDX
                                                   : IW'(p_c[FRAC_BITS +: IW] + 1'b1);
      frac4_q <= p_c[FRAC_BITS-1:0];
    end
  end

  // -------- stage 5: ROM read, t^2
  side_t                side5_q;
  logic [TW-1:0]        t5_q, a5_q, lo5_q, hi5_q, sq5_q;
  logic [FRAC_BITS-1:0] frac5_q;
  logic [2*TW-1:0]      sq_c;

  assign sq_c = a4_q * a4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= side4_q;
      t5_q    <= t4_q;
      a5_q    <= a4_q;
      frac5_q <= frac4_q;
      lo5_q   <= rom_c[idx4_q];
      hi5_q   <= rom_c[idx14_q];
      sq5_q   <= sq_c[FRAC_BITS +: TW];
    end
  end

  // -------- stage 6: interpolation product, t^4
  side_t                   side6_q;
  logic [TW-1:0]           t6_q, a6_q, lo6_q, dl6_q, q46_q;
  logic                    mono6_q;
  logic [TW+FRAC_BITS-1:0] dp_c;
  logic [2*TW-1:0]         q4_c;

  assign dp_c = TW'(hi5_q - lo5_q) * frac5_q;
  assign q4_c = sq5_q * sq5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side6_q <= side5_q;
      t6_q    <= t5_q;
      a6_q    <= a5_q;
      lo6_q   <= lo5_q;
      mono6_q <= hi5_q >= lo5_q;
      dl6_q   <= dp_c[FRAC_BITS +: TW];
      q46_q   <= q4_c[FRAC_BITS +: TW];
    end
  end

  // -------- stage 7: sine value, t^5
  side_t           side7_q;
  logic [TW-1:0]   t7_q, s7_q, p7_q;
  logic [2*TW-1:0] q5_c;

  assign q5_c = q46_q * a6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side7_q <= side6_q;
      t7_q    <= t6_q;
      s7_q    <= mono6_q ? TW'(lo6_q + dl6_q) : lo6_q;
      p7_q    <= q5_c[FRAC_BITS +: TW];
    end
  end

  // -------- stage 8: curve select, value in units of 2^-(FRAC_BITS+1)
  side_t         side8_q;
  logic [NW-1:0] num_c, num8_q;

  always_comb begin
    case (side7_q.mode)
      MODE_LINEAR: num_c = {t7_q, 1'b0};
      MODE_SINE:   num_c = {s7_q, 1'b0};
      MODE_COSINE: num_c = {TW'(ONE_Q - s7_q), 1'b0};
      MODE_POLY5:  num_c = {p7_q, 1'b0};
      MODE_MPOLY5: num_c = {TW'(ONE_Q - p7_q), 1'b0};
      MODE_MIXED: begin
        if (side7_q.mix_full) begin
          num_c = {ONE_Q, 1'b0};
        end else if (side7_q.mix_hi) begin
          num_c = NW'({ONE_Q, 1'b0} - {1'b0, p7_q});
        end else begin
          num_c = {1'b0, p7_q};
        end
      end
      default:     num_c = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side8_q <= side7_q;
      num8_q  <= num_c;
    end
  end

  // -------- stage 9: scale by |range|
  side_t            side9_q;
  logic [16:0]      mag_c, res9_q;
  logic [NW+16:0]   prod_c;

  assign mag_c  = side8_q.rng[16] ? 17'(-side8_q.rng) : side8_q.rng;
  assign prod_c = num8_q * mag_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side9_q <= side8_q;
      res9_q  <= prod_c[FRAC_BITS+1 +: 17];
    end
  end

  // -------- stage 10: sign and output word
  logic [16:0] off10_q;
  logic        done10_q, inval10_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (side9_q.inval) begin
        off10_q <= '0;
      end else begin
        off10_q <= side9_q.rng[16] ? 17'(-res9_q) : res9_q;
      end
      done10_q  <= side9_q.done;
      inval10_q <= side9_q.inval;
    end
  end

  assign out_valid_o = v10_q;
  assign offset_o    = $signed(off10_q);
  assign done_res_o  = done10_q;
  assign invalid_o   = inval10_q;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for easing_curve_interpolator
// Sends timed move words through the valid/stall input, predicts every eased
// offset, done and invalid flag in-house and compares the output words in
// order, with random idle gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eci_pkg::*;

  localparam int FB    = 16;
  localparam int DEPTH = 1024;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam longint unsigned HPI = 64'd1686629713;  // pi/2, Q30
  localparam int LATENCY = FB + 10;

  typedef struct {
    logic signed [16:0] offset;
    logic               done;
    logic               inval;
  } eased_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [2:0] curve_mode = '0;
  logic [31:0] start_time = '0;
  logic [31:0] now_time = '0;
  logic [23:0] duration = '0;
  logic signed [15:0] start_value = '0;
  logic signed [15:0] end_value = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, done_res, invalid;
  logic signed [16:0] offset;

  eased_t expected_q[$];
  longint unsigned sine_tab[DEPTH+1];
  int mismatches = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  bit out_take = 1'b0;

  easing_curve_interpolator #(.FRAC_BITS(FB), .TABLE_DEPTH(DEPTH)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .curve_mode_i(curve_mode), .start_time_i(start_time), .now_time_i(now_time),
    .duration_i(duration), .start_value_i(start_value), .end_value_i(end_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .offset_o(offset), .done_res_o(done_res), .invalid_o(invalid)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // quarter sine, Q0.FB, from a Taylor series in Q30
  task automatic fill_sine;
    longint unsigned x, term, v;
    longint signed acc;
    for (int i = 0; i <= DEPTH; i++) begin
      x = HPI * longint'(i) / DEPTH;
      term = x;
      acc = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
      if (acc < 0) acc = 0;
      v = ((longint'(acc) << FB) + (64'd1 << 29)) >> 30;
      if (v > ONE) v = ONE;
      sine_tab[i] = v;
    end
    sine_tab[0] = 0;
    sine_tab[DEPTH] = ONE;
  endtask

  function automatic longint unsigned sine_at(longint unsigned t);
    longint unsigned p, idx, fr, lo, hi;
    p = t * DEPTH;
    idx = p >> FB;
    fr = p & (ONE - 1);
    if (idx >= DEPTH) return sine_tab[DEPTH];
    lo = sine_tab[idx];
    hi = sine_tab[idx+1];
    if (hi < lo) return lo;
    return lo + (((hi - lo) * fr) >> FB);
  endfunction

  function automatic longint unsigned fifth_power(longint unsigned t);
    longint unsigned t2, t4;
    t2 = (t * t) >> FB;
    t4 = (t2 * t2) >> FB;
    return (t4 * t) >> FB;
  endfunction

  function automatic longint unsigned fraction(longint signed el, longint unsigned den);
    if (den == 0) return ONE;
    if (el <= 0) return 0;
    if (longint'(el) >= longint'(den)) return ONE;
    return (longint'(el) << FB) / den;
  endfunction

  function automatic eased_t ease(logic [2:0] m, logic [31:0] st, logic [31:0] nt,
                                  logic [23:0] dur, logic signed [15:0] sv,
                                  logic signed [15:0] ev);
    eased_t r;
    logic [31:0] diff;
    longint signed el, rng, sres;
    longint unsigned t, num, mag, h, d;
    diff = nt - st;
    el = longint'($signed(diff));
    d = longint'(dur);
    rng = longint'(ev) - longint'(sv);
    t = fraction(el, d);
    num = 0;
    case (m)
      MODE_LINEAR: num = 2 * t;
      MODE_SINE:   num = 2 * sine_at(t);
      MODE_COSINE: num = 2 * (ONE - sine_at(ONE - t));
      MODE_POLY5:  num = 2 * fifth_power(t);
      MODE_MPOLY5: num = 2 * (ONE - fifth_power(ONE - t));
      MODE_MIXED: begin
        if (d == 0) begin
          num = 2 * ONE;
        end else begin
          h = d >> 1;
          if (el > longint'(h))
            num = ONE + (ONE - fifth_power(ONE - fraction(el - longint'(h), h)));
          else
            num = fifth_power(fraction(el, h));
        end
      end
      default: num = 0;
    endcase
    sres = 0;
    if (m <= MODE_MIXED) begin
      mag = (rng < 0) ? -rng : rng;
      sres = longint'((num * mag) >> (FB + 1));
      if (rng < 0) sres = -sres;
    end
    r.offset = sres[16:0];
    r.done = (el >= longint'(d));
    r.inval = (m > MODE_MIXED);
    return r;
  endfunction

  // one input word; caller sits just after a rising edge
  task automatic send_word(logic [2:0] m, logic [31:0] st, logic [31:0] nt,
                           logic [23:0] dur, logic signed [15:0] sv,
                           logic signed [15:0] ev);
    int gap;
    bit stalled;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    curve_mode <= m; start_time <= st; now_time <= nt;
    duration <= dur; start_value <= sv; end_value <= ev;
    expected_q.insert(expected_q.size(), ease(m, st, nt, dur, sv, ev));
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
  endtask

  // output side: accepted at the next edge when valid and not stalled at negedge
  always @(negedge clk) begin
    eased_t e;
    out_take = rst_n && out_valid && !out_stall;
    if (out_take) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: offset %0d", offset);
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (offset !== e.offset || done_res !== e.done || invalid !== e.inval) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp offset %0d done %0b inv %0b, got %0d %0b %0b",
                     e.offset, e.done, e.inval, offset, done_res, invalid);
        end
      end
    end
  end

  // after each taken word, stall for a drawn number of cycles
  always @(posedge clk) begin
    int wait_n;
    if (out_take) begin
      wait_n = no_idle ? 0 : $urandom_range(0, 13);
      stall_left <= wait_n;
      out_stall <= (wait_n > 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_directed;
    logic [2:0] m;
    for (int i = 0; i < 8; i++) begin
      m = i[2:0];
      send_word(m, 32'd100, 32'd150, 24'd100, -16'sd32768, 16'sd32767);
      send_word(m, 32'd7, 32'd7, 24'd0, 16'sd32767, -16'sd32768);
    end
    send_word(MODE_LINEAR, 32'hFFFF_FFF0, 32'h0000_0010, 24'hFF_FFFF, 16'sd0, 16'sd1000);
    send_word(MODE_SINE, 32'h0000_0010, 32'hFFFF_FFF0, 24'd50, 16'sd5, 16'sd9);
    send_word(MODE_MIXED, 32'd0, 32'd0, 24'd1, 16'sd0, 16'sd32767);
    send_word(MODE_MIXED, 32'd0, 32'd1, 24'd1, 16'sd0, -16'sd32768);
    send_word(MODE_MIXED, 32'd0, 32'd75, 24'd100, 16'sd100, -16'sd100);
    send_word(MODE_COSINE, 32'd0, 32'd64, 24'd64, 16'sd0, 16'sd32767);
    send_word(MODE_MPOLY5, 32'h8000_0000, 32'h7FFF_FFFF, 24'd3, 16'sd1, 16'sd0);
    send_word(MODE_POLY5, 32'd0, 32'hFF_FFFE, 24'hFF_FFFF, -16'sd32768, 16'sd32767);
  endtask

  task automatic test_random;
    logic [2:0] m;
    logic [31:0] st, nt;
    logic [23:0] dur;
    logic signed [15:0] sv, ev;
    int w;
    for (int i = 0; i < 1500; i++) begin
      if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
      m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      st = $urandom;
      sv = 16'($urandom);
      ev = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        nt = $urandom;
        dur = 24'($urandom);
      end else begin
        w = $urandom_range(0, 24);
        dur = (w == 0) ? 24'd0 : 24'($urandom & ((32'd1 << w) - 1));
        // elapsed around the move, a little before and past it
        nt = st + 32'($urandom_range(0, 32'(dur) + 40)) - 32'd20;
      end
      send_word(m, st, nt, dur, sv, ev);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int waited;
    fill_sine();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/eci_pkg.sv
hw/rtl/eci_div.sv
hw/rtl/easing_curve_interpolator.sv
test/testbench.sv
